// ===== hdl/bsc_pkg.sv =====
`default_nettype none
package bsc_pkg;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AC12 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AC34 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AC56 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B12 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MCMD = 3'd5;

	typedef struct packed {
		logic [15:0] raw_temperature;
		logic [23:0] raw_pressure;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] temperature_tenths;
		logic signed [31:0] pressure_pa;
		logic divide_fault;
	} out_item_t;

	typedef struct packed {
		logic [1:0] oss;
		logic [31:0] ac12;
		logic [31:0] ac34;
		logic [31:0] ac56;
		logic [31:0] b12;
		logic [31:0] mcmd;
	} cal_t;

	// Arithmetic shift right on a 32-bit word
	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
		asr32 = 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] h);
		sx16 = {{16{h[15]}}, h};
	endfunction
endpackage
`default_nettype wire

// ===== hdl/bsc_if.sv =====
`default_nettype none
interface bsc_in_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bsc_out_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bsc_cfg_if;
	import bsc_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/bsc_divider.sv =====
`default_nettype none
module bsc_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] dividend,
	input wire logic [31:0] divisor,
	output logic done,
	output logic [31:0] quotient
);
	import bsc_pkg::*;

	// Restoring unsigned division, one quotient bit per cycle
	logic [5:0] cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= 6'd32;
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hdl/bsc_front.sv =====
`default_nettype none
module bsc_front (
	input wire logic clk,
	input wire logic arst_n,
	bsc_in_if.sink in_ch,
	bsc_cfg_if.sink cfg,
	output bsc_pkg::cal_t cal,
	output logic q_valid,
	output bsc_pkg::in_item_t q_data,
	input wire logic q_pop
);
	import bsc_pkg::*;

	// Two-entry queue between front and back
	in_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	cal_t cal_q;

	assign cfg.ready = 1'b1;
	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];
	assign cal = cal_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OSS: cal_q.oss <= cfg.wdata[1:0];
				REG_AC12: cal_q.ac12 <= cfg.wdata;
				REG_AC34: cal_q.ac34 <= cfg.wdata;
				REG_AC56: cal_q.ac56 <= cfg.wdata;
				REG_B12: cal_q.b12 <= cfg.wdata;
				REG_MCMD: cal_q.mcmd <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Advance queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_ch.data;
	end
endmodule
`default_nettype wire

// ===== hdl/bsc_back.sv =====
`default_nettype none
module bsc_back (
	input wire logic clk,
	input wire logic arst_n,
	input bsc_pkg::cal_t cal,
	input wire logic q_valid,
	input bsc_pkg::in_item_t q_data,
	output logic q_pop,
	bsc_out_if.source out_ch
);
	import bsc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_T1, S_T2, S_TDIV, S_T3, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
		S_PDIV, S_P7, S_P8, S_P9, S_P10, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] ut_q, up_q, x1_q, b5_q, b6_q, sq_q, a_q, b_q, c_q, b3_q, b4_q, b7_q, p_q;
	logic fault_q, div_wait_q, hi_q;
	logic [31:0] mul_a, mul_b, prod;
	logic div_start, div_done;
	logic [31:0] div_n, div_d, div_q;
	logic [1:0] oss;
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] t, num, ma, md_abs;
	logic [31:0] tdiv_d, b3_num;
	logic neg_q;
	logic res_load;
	out_item_t res_q;
	logic res_v_q;

	assign oss = cal.oss;
	assign ac1 = sx16(cal.ac12[31:16]);
	assign ac2 = sx16(cal.ac12[15:0]);
	assign ac3 = sx16(cal.ac34[31:16]);
	assign ac4 = {16'd0, cal.ac34[15:0]};
	assign ac5 = {16'd0, cal.ac56[31:16]};
	assign ac6 = {16'd0, cal.ac56[15:0]};
	assign b1 = sx16(cal.b12[31:16]);
	assign b2 = sx16(cal.b12[15:0]);
	assign mc = sx16(cal.mcmd[31:16]);
	assign md = sx16(cal.mcmd[15:0]);

	assign prod = mul_a * mul_b;
	assign t = asr32(b5_q + 32'd8, 5'd4);
	assign num = mc << 11;
	assign tdiv_d = x1_q + md;
	assign b3_num = (((ac1 << 2) + a_q + asr32(prod, 5'd11)) << oss) + 32'd2;

	bsc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_n),
		.divisor(div_d), .done(div_done), .quotient(div_q)
	);

	// Select multiplier operands per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_T1: begin mul_a = ut_q - ac6; mul_b = ac5; end
			S_P1: begin mul_a = b6_q; mul_b = b6_q; end
			S_P2: begin mul_a = b2; mul_b = sq_q; end
			S_P3: begin mul_a = ac2; mul_b = b6_q; end
			S_P4: begin mul_a = ac3; mul_b = b6_q; end
			S_P5: begin mul_a = b1; mul_b = sq_q; end
			S_P6: begin mul_a = ac4; mul_b = c_q; end
			S_P7: begin mul_a = up_q - b3_q; mul_b = 32'd50000 >> oss; end
			S_P9: begin mul_a = asr32(p_q, 5'd8); mul_b = asr32(p_q, 5'd8); end
			S_P10: begin mul_a = a_q; mul_b = 32'd3038; end
			default: ;
		endcase
	end

	// Start the shared divider on entry to a divide step
	always_comb begin
		div_start = 1'b0;
		div_n = '0;
		div_d = '0;
		ma = num[31] ? 32'd0 - num : num;
		md_abs = tdiv_d[31] ? 32'd0 - tdiv_d : tdiv_d;
		if (state_q == S_TDIV && !div_wait_q) begin
			div_start = 1'b1;
			div_n = ma;
			div_d = md_abs;
		end else if (state_q == S_PDIV && !div_wait_q) begin
			div_start = 1'b1;
			div_n = hi_q ? b7_q : b7_q << 1;
			div_d = b4_q;
		end
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign res_load = (state_q == S_OUT) && (!res_v_q || out_ch.ready);
	assign out_ch.valid = res_v_q;
	assign out_ch.data = res_q;

	// Sequence one item through the shared multiplier and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_wait_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (res_load) res_v_q <= 1'b1;
			else if (out_ch.ready) res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_valid) state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_TDIV;
				S_TDIV: begin
					if (!div_wait_q) div_wait_q <= 1'b1;
					else if (div_done) begin
						div_wait_q <= 1'b0;
						state_q <= S_T3;
					end
				end
				S_T3: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: state_q <= S_P6;
				S_P6: state_q <= S_P7;
				S_P7: state_q <= S_PDIV;
				S_PDIV: begin
					if (!div_wait_q) div_wait_q <= 1'b1;
					else if (div_done) begin
						div_wait_q <= 1'b0;
						state_q <= S_P8;
					end
				end
				S_P8: state_q <= S_P9;
				S_P9: state_q <= S_P10;
				S_P10: state_q <= S_OUT;
				S_OUT: if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ut_q <= {16'd0, q_data.raw_temperature};
				up_q <= {8'd0, q_data.raw_pressure} >> (4'd8 - {2'd0, oss});
				fault_q <= 1'b0;
			end
			S_T1: x1_q <= asr32(prod, 5'd15);
			S_T2: neg_q <= num[31] ^ tdiv_d[31];
			S_TDIV: begin
				if (!div_wait_q && tdiv_d == 32'd0) fault_q <= 1'b1;
				if (div_wait_q && div_done) begin
					if (tdiv_d == 32'd0) b5_q <= x1_q;
					else b5_q <= x1_q + (neg_q ? 32'd0 - div_q : div_q);
				end
			end
			S_T3: b6_q <= b5_q - 32'd4000;
			S_P1: sq_q <= asr32(prod, 5'd12);
			S_P2: a_q <= asr32(prod, 5'd11);
			// Divide by four, rounding toward zero
			S_P3: b3_q <= asr32(b3_num, 5'd2) + {31'd0, b3_num[31] & (|b3_num[1:0])};
			S_P4: a_q <= asr32(prod, 5'd13);
			S_P5: c_q <= asr32(a_q + asr32(prod, 5'd16) + 32'd2, 5'd2) + 32'd32768;
			S_P6: b4_q <= prod >> 15;
			S_P7: begin
				b7_q <= prod;
				hi_q <= prod[31];
			end
			S_PDIV: begin
				if (!div_wait_q && b4_q == 32'd0) fault_q <= 1'b1;
				if (div_wait_q && div_done) begin
					if (b4_q == 32'd0) p_q <= '0;
					else p_q <= hi_q ? div_q << 1 : div_q;
				end
			end
			S_P9: a_q <= prod;
			S_P10: b_q <= asr32(prod, 5'd16) + asr32((32'd0 - 32'd7357) * p_q, 5'd16);
			S_OUT: begin
				if (res_load) begin
					res_q.pressure_pa <= p_q + asr32(b_q + 32'd3791, 5'd4);
					res_q.divide_fault <= fault_q;
					if (t[31]) res_q.temperature_tenths <= (t < 32'hFFFF8000) ? 16'sh8000 : t[15:0];
					else res_q.temperature_tenths <= (t > 32'd32767) ? 16'sh7FFF : t[15:0];
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/barometric_sensor_compensation_top.sv =====
`default_nettype none
// Channel   Dir  Payload
// in_ch     in   raw_temperature[15:0], raw_pressure[23:0]
// cfg       in   index[2:0], wdata[31:0]
// out_ch    out  temperature_tenths, pressure_pa, divide_fault
// Each item passes through two divide steps of the shared 32-bit divider
// and single-cycle multiply steps; the next item is taken once the result is loaded.
// The two-entry input queue keeps accepting while the sequencer works, until it is full.
// Reset clears calibration, queue and control; the result register holds
// its value until out_ch transfers it.
module barometric_sensor_compensation_top (
	input wire logic clk,
	input wire logic arst_n,
	bsc_in_if.sink in_ch,
	bsc_cfg_if.sink cfg,
	bsc_out_if.source out_ch
);
	import bsc_pkg::*;

	cal_t cal;
	logic q_valid, q_pop;
	in_item_t q_data;

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg), .cal(cal),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal), .q_valid(q_valid),
		.q_data(q_data), .q_pop(q_pop), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
	import bsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 400;

	logic clk;
	logic arst_n;

	bsc_in_if in_ch();
	bsc_cfg_if cfg();
	bsc_out_if out_ch();

	barometric_sensor_compensation_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg(cfg),
		.out_ch(out_ch)
	);

	// shadow calibration, updated on each config transfer
	logic [1:0] oss_q;
	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;

	in_item_t readings_q[$];
	out_item_t compensated_q[$];

	logic send_gaps, recv_gaps;
	int stall_req, stall_seen;
	int send_gap, recv_gap, hold_cnt;
	int mismatches, idle_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] shr_s(input logic [31:0] v, input int s);
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] div_s(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		if (b == 32'd0) return 32'd0;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	// datasheet compensation of one reading pair under the shadow calibration
	function automatic out_item_t compensate(input in_item_t r);
		out_item_t o;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, t, sq, dv;
		logic flt;
		flt = 1'b0;
		ac1 = {{16{ac12_q[31]}}, ac12_q[31:16]};
		ac2 = {{16{ac12_q[15]}}, ac12_q[15:0]};
		ac3 = {{16{ac34_q[31]}}, ac34_q[31:16]};
		ac4 = {16'd0, ac34_q[15:0]};
		ac5 = {16'd0, ac56_q[31:16]};
		ac6 = {16'd0, ac56_q[15:0]};
		b1 = {{16{b12_q[31]}}, b12_q[31:16]};
		b2 = {{16{b12_q[15]}}, b12_q[15:0]};
		mc = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
		md = {{16{mcmd_q[15]}}, mcmd_q[15:0]};
		ut = {16'd0, r.raw_temperature};
		up = {8'd0, r.raw_pressure} >> (8 - oss_q);
		// temperature
		x1 = shr_s((ut - ac6) * ac5, 15);
		dv = x1 + md;
		if (dv == 32'd0) flt = 1'b1;
		x2 = div_s(mc << 11, dv);
		b5 = x1 + x2;
		t = shr_s(b5 + 32'd8, 4);
		if ($signed(t) < -32768) o.temperature_tenths = 16'sh8000;
		else if ($signed(t) > 32767) o.temperature_tenths = 16'sh7fff;
		else o.temperature_tenths = t[15:0];
		// pressure
		b6 = b5 - 32'd4000;
		sq = shr_s(b6 * b6, 12);
		x3 = shr_s(b2 * sq, 11) + shr_s(ac2 * b6, 11);
		b3 = div_s(((ac1 * 32'd4 + x3) << oss_q) + 32'd2, 32'd4);
		x1 = shr_s(ac3 * b6, 13);
		x2 = shr_s(b1 * sq, 16);
		x3 = shr_s(x1 + x2 + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		b7 = (up - b3) * (32'd50000 >> oss_q);
		if (b4 == 32'd0) begin
			flt = 1'b1;
			p = 32'd0;
		end else if (!b7[31]) begin
			p = (b7 * 32'd2) / b4;
		end else begin
			p = (b7 / b4) * 32'd2;
		end
		x1 = shr_s(p, 8) * shr_s(p, 8);
		x1 = shr_s(x1 * 32'd3038, 16);
		x2 = shr_s(32'(-7357) * p, 16);
		o.pressure_pa = p + shr_s(x1 + x2 + 32'd3791, 4);
		o.divide_fault = flt;
		return o;
	endfunction

	// sender: feed readings from the queue, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			send_gap <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (readings_q.size() > 0) begin
				in_ch.data <= readings_q.pop_front();
				in_ch.valid <= 1'b1;
				if (send_gaps && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 4);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
			hold_cnt <= 0;
			stall_seen <= 0;
		end else if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			hold_cnt <= LONG_HOLD;
			out_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (recv_gaps && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 4);
		end
	end

	// predict on each input transfer, check on each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) compensated_q.push_back(compensate(in_ch.data));
			if (out_ch.valid && out_ch.ready) begin
				if (compensated_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
				end else begin
					out_item_t exp_r;
					exp_r = compensated_q.pop_front();
					if (out_ch.data.temperature_tenths !== exp_r.temperature_tenths ||
					    out_ch.data.pressure_pa !== exp_r.pressure_pa ||
					    out_ch.data.divide_fault !== exp_r.divide_fault) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp T=%0d P=%0d F=%0b got T=%0d P=%0d F=%0b",
								exp_r.temperature_tenths, exp_r.pressure_pa,
								exp_r.divide_fault, out_ch.data.temperature_tenths,
								out_ch.data.pressure_pa, out_ch.data.divide_fault);
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
		    (cfg.valid && cfg.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.wdata <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_OSS: oss_q = val[1:0];
			REG_AC12: ac12_q = val;
			REG_AC34: ac34_q = val;
			REG_AC56: ac56_q = val;
			REG_B12: b12_q = val;
			REG_MCMD: mcmd_q = val;
			default: ;
		endcase
	endtask

	task automatic load_cal(input logic [31:0] a12, a34, a56, bb, mm);
		write_reg(REG_AC12, a12);
		write_reg(REG_AC34, a34);
		write_reg(REG_AC56, a56);
		write_reg(REG_B12, bb);
		write_reg(REG_MCMD, mm);
	endtask

	// hold until every reading has been transferred and answered
	task automatic drain();
		do @(posedge clk);
		while (readings_q.size() > 0 || in_ch.valid || compensated_q.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic add_reading(input logic [15:0] ut, input logic [23:0] up);
		in_item_t r;
		r.raw_temperature = ut;
		r.raw_pressure = up;
		readings_q.push_back(r);
	endtask

	// mostly plausible readings, some full-range noise
	task automatic add_random();
		if ($urandom_range(0, 3) != 0)
			add_reading(16'($urandom_range(20000, 36000)),
				24'($urandom_range(20000, 50000) << 8 | $urandom_range(0, 255)));
		else
			add_reading(16'($urandom), 24'($urandom));
	endtask

	initial begin
		int ph;
		oss_q = '0;
		{ac12_q, ac34_q, ac56_q, b12_q, mcmd_q} = '0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		stall_req = 0;
		mismatches = 0;
		idle_cycles = 0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.wdata = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset calibration: both divisors zero
		add_reading(16'h0000, 24'h000000);
		add_reading(16'hffff, 24'hffffff);
		add_reading(16'h5555, 24'haaaaaa);
		add_reading(16'haaaa, 24'h555555);
		drain();

		// typical calibration over all oversampling settings; bits above oss ignored
		load_cal({16'd408, 16'hffb8}, {16'hc7d1, 16'd32741}, {16'd32757, 16'd23153},
			{16'd6190, 16'd4}, {16'hddf9, 16'd2868});
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_OSS, 32'hfffffffc | m);
			add_reading(16'd27898, 24'(23843 << 8));
			add_reading(16'h0000, 24'h000000);
			add_reading(16'hffff, 24'hffffff);
			drain();
		end
		// out-of-range indexes are ignored
		write_reg(3'd6, 32'hffffffff);
		write_reg(3'd7, 32'h12345678);
		add_reading(16'd27898, 24'(23843 << 8));
		drain();

		// extreme calibration words
		write_reg(REG_OSS, 32'd3);
		load_cal('1, '1, '1, '1, '1);
		add_reading(16'h0000, 24'hffffff);
		add_reading(16'hffff, 24'h000000);
		drain();
		load_cal(32'h7fff8000, 32'h8000ffff, 32'hffff0000, 32'h80007fff, 32'h7fff8000);
		add_reading(16'hffff, 24'hffffff);
		add_reading(16'h0000, 24'h000001);
		drain();
		// ac4 zero, and ac5 and md zero so x1 + md is zero: both divide faults
		load_cal({16'd408, 16'hffb8}, {16'hc7d1, 16'd0}, {16'd0, 16'd23153},
			{16'd6190, 16'd4}, {16'hddf9, 16'd0});
		add_reading(16'd27898, 24'(23843 << 8));
		drain();

		// random phases
		for (ph = 0; ph < 10; ph++) begin
			write_reg(REG_OSS, $urandom);
			if (ph % 3 == 0)
				load_cal({16'($urandom_range(0, 800)), 16'($urandom_range(0, 200) - 100)},
					{16'($urandom_range(0, 4000) - 16000), 16'($urandom_range(30000, 34000))},
					{16'($urandom_range(24000, 33000)), 16'($urandom_range(15000, 25000))},
					{16'($urandom_range(5000, 7000)), 16'($urandom_range(0, 8))},
					{16'($urandom_range(0, 2000) - 9500), 16'($urandom_range(2000, 3000))});
			else
				load_cal($urandom, $urandom, $urandom, $urandom, $urandom);
			if (ph == 9) begin
				send_gaps = 1'b0;
				recv_gaps = 1'b0;
			end
			for (int k = 0; k < 113; k++) add_random();
			// long receiver hold while the sender keeps offering
			if (ph == 4) stall_req = stall_req + 1;
			drain();
		end

		drain();
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
